>>> design/plls_pkg.sv
package plls_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int BURST_WORDS = 16;

	localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int IDX_W = 8;
	localparam int COLOR_W = 16;
	localparam int COORD_W = 16;
	localparam int WBLK_W = 11;
	localparam int BURST_W = 4;
	localparam int WORD_W = 32;
	localparam int KIND_W = 2;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [KIND_W-1:0] KIND_CMD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WIN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PIX = 2'd2;

	localparam logic [7:0] CMD_CASET = 8'h2A;
	localparam logic [7:0] CMD_PASET = 8'h2B;
	localparam logic [7:0] CMD_RAMWR = 8'h2C;

	localparam logic [CFG_IDX_W-1:0] REG_X_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_BLOCKS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

	localparam logic [PHASE_W-1:0] HDR_CASET = 3'd0;
	localparam logic [PHASE_W-1:0] HDR_COL = 3'd1;
	localparam logic [PHASE_W-1:0] HDR_PASET = 3'd2;
	localparam logic [PHASE_W-1:0] HDR_ROW = 3'd3;
	localparam logic [PHASE_W-1:0] HDR_RAMWR = 3'd4;

	localparam logic [BURST_W-1:0] BURST_LAST = BURST_W'(BURST_WORDS - 1);

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [WORD_W-1:0] pack_pair(input logic [15:0] lo, input logic [15:0] hi);
		return {swap16(hi), swap16(lo)};
	endfunction

endpackage

>>> design/plls_ram.sv
module plls_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/palette_lcd_line_streamer_core.sv
// Pixel word: the taken pixel is registered in stage 1 with its palette read, then packed into the output register.
// Throughput: one item per cycle while the output is not stalled; the first pixel of a line holds
// the input while the five header words go out.
// Palette lookup: one registered read of the palette RAM, then packing into the output register.
// Reset: arst_n clears all control state and the 256 palette valid bits at once,
// so every entry reads zero until written; no clearing pass.
module palette_lcd_line_streamer_core
	import plls_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // pixel_index[7:0], palette_color[23:8]
	input  logic [1:0]           s_tuser,   // mode[0], blank[1]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [WORD_W-1:0]    m_tdata,   // tx_word[31:0]
	output logic [3:0]           m_tuser,   // dc_level[0], tx_kind[2:1], burst_end[3]
	output logic                 m_tlast,   // last_of_run
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	logic [COORD_W-1:0] x_start_q, y_start_q, height_q;
	logic [WBLK_W-1:0]  width_blocks_q;

	logic [COORD_W-1:0] column_q, line_q;
	logic [COLOR_W-1:0] pending_q;
	logic [BURST_W-1:0] burst_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PALETTE_ENTRIES-1:0] pal_valid_q;

	logic               valid_s1, mode_s1, blank_s1, hit_s1;
	logic [COLOR_W-1:0] rdata;

	logic               m_tvalid_s2, m_tlast_s2;
	logic [WORD_W-1:0]  m_tdata_s2;
	logic [3:0]         m_tuser_s2;

	logic               in_take, in_mode, in_blank, in_range;
	logic [IDX_W-1:0]   in_idx;
	logic [COLOR_W-1:0] in_color;
	logic [PAL_AW-1:0]  pal_addr;

	logic               out_free, is_pix, hdr, odd, emit, s1_adv, pix_done, line_last, bend;
	logic [COORD_W-1:0] line_end, x_end, row, y_end;
	logic [COLOR_W-1:0] color;
	logic               e_dc, e_bend, e_last;
	logic [KIND_W-1:0]  e_kind;
	logic [WORD_W-1:0]  e_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q      <= '0;
			y_start_q      <= '0;
			width_blocks_q <= WBLK_W'(8);
			height_q       <= COORD_W'(240);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_X_START:      x_start_q <= cfg_data;
				REG_Y_START:      y_start_q <= cfg_data;
				REG_WIDTH_BLOCKS: width_blocks_q <= cfg_data[WBLK_W-1:0];
				REG_HEIGHT:       height_q <= cfg_data;
				default:          x_start_q <= x_start_q;
			endcase
		end
	end

	assign in_take  = s_tvalid & s_tready;
	assign in_mode  = s_tuser[0];
	assign in_blank = s_tuser[1];
	assign in_idx   = s_tdata[7:0];
	assign in_color = s_tdata[23:8];
	assign in_range = {1'b0, in_idx} < 9'(PALETTE_ENTRIES);
	assign pal_addr = in_idx[PAL_AW-1:0];

	plls_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (in_take & in_mode & in_range),
		.waddr(pal_addr),
		.wdata(in_color),
		.re   (in_take & ~in_mode),
		.raddr(pal_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (in_take & in_mode & in_range) begin
			pal_valid_q[pal_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1  <= in_mode;
			blank_s1 <= in_blank;
			hit_s1   <= in_range & pal_valid_q[pal_addr];
		end
	end

	assign out_free  = ~m_tvalid_s2 | m_tready;
	assign is_pix    = valid_s1 & ~mode_s1;
	assign hdr       = is_pix & (column_q == '0);
	assign odd       = column_q[0];
	assign emit      = is_pix & (hdr | odd);
	assign s1_adv    = valid_s1 & (mode_s1 | (hdr ? (phase_q == HDR_RAMWR) & out_free
	                                               : (~odd | out_free)));
	assign pix_done  = is_pix & s1_adv;
	assign s_tready  = ~valid_s1 | s1_adv;

	assign line_end  = {width_blocks_q, 5'b0} - COORD_W'(1);
	assign x_end     = x_start_q + line_end;
	assign row       = y_start_q + line_q;
	assign y_end     = row + height_q - COORD_W'(1);
	assign color     = (~blank_s1 & hit_s1) ? rdata : '0;
	assign line_last = (column_q == line_end);
	assign bend      = line_last | (burst_q >= BURST_LAST);

	always_comb begin
		e_dc   = 1'b1;
		e_kind = KIND_PIX;
		e_bend = bend;
		e_last = 1'b1;
		e_word = pack_pair(pending_q, color);
		if (hdr) begin
			e_bend = 1'b1;
			e_last = 1'b0;
			case (phase_q)
				HDR_CASET: begin
					e_dc   = 1'b0;
					e_kind = KIND_CMD;
					e_word = {24'h0, CMD_CASET};
				end
				HDR_COL: begin
					e_kind = KIND_WIN;
					e_word = pack_pair(x_start_q, x_end);
				end
				HDR_PASET: begin
					e_dc   = 1'b0;
					e_kind = KIND_CMD;
					e_word = {24'h0, CMD_PASET};
				end
				HDR_ROW: begin
					e_kind = KIND_WIN;
					e_word = pack_pair(row, y_end);
				end
				default: begin
					e_dc   = 1'b0;
					e_kind = KIND_CMD;
					e_last = 1'b1;
					e_word = {24'h0, CMD_RAMWR};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HDR_CASET;
		end else if (hdr & out_free) begin
			phase_q <= (phase_q == HDR_RAMWR) ? HDR_CASET : phase_q + PHASE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			line_q    <= '0;
			pending_q <= '0;
			burst_q   <= '0;
		end else if (pix_done) begin
			if (~odd) begin
				pending_q <= color;
			end else begin
				burst_q <= bend ? '0 : burst_q + BURST_W'(1);
			end
			if (line_last) begin
				column_q <= '0;
				line_q   <= (line_q == height_q - COORD_W'(1)) ? '0 : line_q + COORD_W'(1);
			end else begin
				column_q <= column_q + COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_s2 <= 1'b0;
		end else if (out_free) begin
			m_tvalid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free & emit) begin
			m_tdata_s2 <= e_word;
			m_tuser_s2 <= {e_bend, e_kind, e_dc};
			m_tlast_s2 <= e_last;
		end
	end

	assign m_tvalid = m_tvalid_s2;
	assign m_tdata  = m_tdata_s2;
	assign m_tuser  = m_tuser_s2;
	assign m_tlast  = m_tlast_s2;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= HDR_RAMWR)
		else $error("header phase out of range");

	a_phase_owner: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != HDR_CASET |-> hdr)
		else $error("header phase active without a line-start pixel");

	a_hdr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		hdr & phase_q != HDR_RAMWR |-> !s_tready)
		else $error("input taken while header in progress");

	a_burst_range: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q <= BURST_LAST)
		else $error("burst word count overran");

	a_pix_follow: assert property (@(posedge clk) disable iff (!arst_n)
		pix_done & odd |=> m_tvalid && m_tlast && m_tuser[2:1] == KIND_PIX)
		else $error("pixel word not presented after odd column");

endmodule

>>> tb/palette_lcd_line_streamer_core_tb.sv
module palette_lcd_line_streamer_core_tb;
	import plls_pkg::*;

	localparam logic MODE_PIXEL  = 1'b0;
	localparam logic MODE_PAL_WR = 1'b1;
	localparam logic DC_CMD      = 1'b0;
	localparam logic DC_DATA     = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [IDX_W-1:0]    idx;
		logic                blank;
		logic [COLOR_W-1:0]  color;
	} pix_item_t;

	typedef struct packed {
		logic                dc;
		logic [WORD_W-1:0]   word;
		logic [KIND_W-1:0]   kind;
		logic                bend;
		logic                last;
	} spi_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;   // pixel_index[7:0], palette_color[23:8]
	logic [1:0]           s_tuser = '0;   // mode[0], blank[1]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [WORD_W-1:0]    m_tdata;        // tx_word[31:0]
	logic [3:0]           m_tuser;        // dc_level[0], tx_kind[2:1], burst_end[3]
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	palette_lcd_line_streamer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mirror of the block's state and window registers
	logic [COLOR_W-1:0]  pal_mirror [PALETTE_ENTRIES];
	logic [15:0]         win_x, win_y, win_h;
	logic [WBLK_W-1:0]   win_wblk;
	logic [15:0]         col_cnt, line_cnt;
	logic [COLOR_W-1:0]  held_color;
	logic [BURST_W-1:0]  burst_cnt;

	pix_item_t   pixel_feed_q [$];
	spi_word_t   spi_words_due [$];
	logic [7:0]  pal_used [$];
	pix_item_t   on_bus;
	spi_word_t   due;
	int          mismatches = 0;
	int          tx_gap, tx_calm, rx_gap, rx_calm, rx_hold, words_seen;
	logic        hold_done;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [WORD_W-1:0] swap_pair(input logic [15:0] lo, input logic [15:0] hi);
		return {hi[7:0], hi[15:8], lo[7:0], lo[15:8]};
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic void predict_spi_words(input pix_item_t it);
		spi_word_t          run [6];
		int                 n;
		logic [15:0]        end_col, row;
		logic [COLOR_W-1:0] color;
		logic               at_end, closes;
		n = 0;
		if (it.mode == MODE_PAL_WR) begin
			pal_mirror[it.idx] = it.color;
		end else begin
			end_col = {win_wblk, 5'd0} - 16'd1;
			if (col_cnt == 16'd0) begin
				row = win_y + line_cnt;
				run[0] = '{DC_CMD, {24'd0, CMD_CASET}, KIND_CMD, 1'b1, 1'b0};
				run[1] = '{DC_DATA, swap_pair(win_x, win_x + end_col), KIND_WIN, 1'b1, 1'b0};
				run[2] = '{DC_CMD, {24'd0, CMD_PASET}, KIND_CMD, 1'b1, 1'b0};
				run[3] = '{DC_DATA, swap_pair(row, row + win_h - 16'd1), KIND_WIN, 1'b1, 1'b0};
				run[4] = '{DC_CMD, {24'd0, CMD_RAMWR}, KIND_CMD, 1'b1, 1'b0};
				n = 5;
			end
			color = it.blank ? '0 : pal_mirror[it.idx];
			at_end = (col_cnt == end_col);
			if (!col_cnt[0]) begin
				held_color = color;
			end else begin
				closes = at_end || (burst_cnt >= BURST_W'(BURST_WORDS - 1));
				run[3'(n)] = '{DC_DATA, swap_pair(held_color, color), KIND_PIX, closes, 1'b0};
				n++;
				burst_cnt = closes ? '0 : burst_cnt + BURST_W'(1);
			end
			if (at_end) begin
				col_cnt = '0;
				line_cnt = (line_cnt == win_h - 16'd1) ? 16'd0 : line_cnt + 16'd1;
			end else begin
				col_cnt = col_cnt + 16'd1;
			end
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				run[3'(i)].last = 1'b1;
			spi_words_due.push_back(run[3'(i)]);
		end
	endfunction

	task automatic flag_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	// sender: present queued items, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			tx_gap <= 0;
			tx_calm <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_spi_words(on_bus);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					s_tvalid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (pixel_feed_q.size() > 0) begin
					on_bus = pixel_feed_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {on_bus.color, on_bus.idx};
					s_tuser <= {on_bus.blank, on_bus.mode};
					if (tx_calm > 0) begin
						tx_calm <= tx_calm - 1;
						tx_gap <= 0;
					end else begin
						tx_gap <= idle_len();
						if ($urandom_range(0, 15) == 0)
							tx_calm <= 40;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, and one long hold to back up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap <= 0;
			rx_calm <= 0;
			rx_hold <= 0;
			words_seen <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				words_seen <= words_seen + 1;
			if (!hold_done && words_seen >= 150) begin
				hold_done <= 1'b1;
				rx_hold <= 400;
				m_tready <= 1'b0;
			end else if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_calm > 0) begin
					rx_calm <= rx_calm - 1;
				end else begin
					rx_gap <= idle_len();
					if ($urandom_range(0, 15) == 0)
						rx_calm <= 40;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (spi_words_due.size() == 0) begin
				flag_mismatch("word with none due", m_tdata, '0);
			end else begin
				due = spi_words_due.pop_front();
				if (m_tuser[0] !== due.dc)
					flag_mismatch("dc_level", 32'(m_tuser[0]), 32'(due.dc));
				if (m_tdata !== due.word)
					flag_mismatch("tx_word", m_tdata, due.word);
				if (m_tuser[2:1] !== due.kind)
					flag_mismatch("tx_kind", 32'(m_tuser[2:1]), 32'(due.kind));
				if (m_tuser[3] !== due.bend)
					flag_mismatch("burst_end", 32'(m_tuser[3]), 32'(due.bend));
				if (m_tlast !== due.last)
					flag_mismatch("last_of_run", 32'(m_tlast), 32'(due.last));
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_X_START: win_x = val;
			REG_Y_START: win_y = val;
			REG_WIDTH_BLOCKS: win_wblk = val[WBLK_W-1:0];
			REG_HEIGHT: win_h = val;
			default: ;
		endcase
	endtask

	task automatic set_window(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] wblk, input logic [15:0] h);
		write_reg(REG_X_START, x);
		write_reg(REG_Y_START, y);
		write_reg(REG_WIDTH_BLOCKS, wblk);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic queue_item(input logic mode, input logic [7:0] idx, input logic blank,
			input logic [15:0] color);
		pixel_feed_q.push_back('{mode, idx, blank, color});
		if (mode == MODE_PAL_WR)
			pal_used.push_back(idx);
	endtask

	// pixels with random content; palette writes mixed in as noise
	task automatic queue_pixels(input int n);
		int         left;
		logic [7:0] idx;
		@(negedge clk);
		left = n;
		while (left > 0) begin
			if ($urandom_range(0, 6) == 0) begin
				queue_item(MODE_PAL_WR, 8'($urandom_range(0, 255)), 1'($urandom),
					16'($urandom));
			end else begin
				if (pal_used.size() > 0 && $urandom_range(0, 3) != 0)
					idx = pal_used[$urandom_range(0, pal_used.size() - 1)];
				else
					idx = 8'($urandom_range(0, 255));
				queue_item(MODE_PIXEL, idx, $urandom_range(0, 9) == 0, 16'($urandom));
				left--;
			end
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pixel_feed_q.size() != 0 || s_tvalid || spi_words_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			pal_mirror[PAL_AW'(i)] = '0;
		win_x = '0;
		win_y = '0;
		win_wblk = 11'd8;
		win_h = 16'd240;
		col_cnt = '0;
		line_cnt = '0;
		held_color = '0;
		burst_cnt = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wrapping window sums, two-line frame
		set_window(16'hFFFF, 16'hFFFF, 16'd1, 16'd2);
		@(negedge clk);
		queue_item(MODE_PAL_WR, 8'd0, 1'b0, 16'hFFFF);
		queue_item(MODE_PAL_WR, 8'd255, 1'b1, 16'hA5C3);
		queue_item(MODE_PAL_WR, 8'd1, 1'b0, 16'h0001);
		queue_item(MODE_PAL_WR, 8'd128, 1'b0, 16'h8000);
		queue_item(MODE_PAL_WR, 8'd37, 1'b0, 16'h5A3C);
		queue_item(MODE_PIXEL, 8'd0, 1'b0, 16'h0000);
		queue_item(MODE_PIXEL, 8'd255, 1'b0, 16'hFFFF);
		queue_item(MODE_PIXEL, 8'd0, 1'b1, 16'h0000);
		queue_item(MODE_PIXEL, 8'd255, 1'b1, 16'h0000);
		queue_item(MODE_PIXEL, 8'd200, 1'b0, 16'h1111);
		queue_item(MODE_PIXEL, 8'd1, 1'b0, 16'h0000);
		queue_item(MODE_PIXEL, 8'd128, 1'b0, 16'h0000);
		queue_item(MODE_PIXEL, 8'd37, 1'b0, 16'h0000);
		queue_item(MODE_PAL_WR, 8'd37, 1'b0, 16'h0000);
		queue_item(MODE_PIXEL, 8'd37, 1'b0, 16'h0000);
		queue_item(MODE_PAL_WR, 8'd1, 1'b0, 16'h1234);
		queue_item(MODE_PIXEL, 8'd1, 1'b0, 16'h0000);
		queue_pixels(54);
		wait_idle();

		// widest line at its header, then shrink it so the line closes
		set_window(16'h0000, 16'h8001, 16'd2047, 16'd65535);
		queue_pixels(6);
		wait_idle();
		write_reg(REG_WIDTH_BLOCKS, 16'd1);
		queue_pixels(26);
		wait_idle();

		// width and height of zero
		set_window(16'h1234, 16'h0000, 16'd0, 16'd0);
		queue_pixels(6);
		wait_idle();
		set_window(16'h1234, 16'h0000, 16'd1, 16'd5);
		queue_pixels(26);
		wait_idle();

		set_window(16'($urandom), 16'($urandom), 16'd1, 16'd1);
		queue_pixels(32);
		wait_idle();
		set_window(16'($urandom), 16'($urandom), 16'd2, 16'd65535);
		queue_pixels(64);
		wait_idle();
		set_window(16'($urandom), 16'($urandom), 16'($urandom_range(1, 2)),
			16'($urandom_range(2, 5)));
		queue_pixels(int'(win_wblk) * 64);
		wait_idle();
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("PASS palette_lcd_line_streamer_core");
		else
			$display("FAIL palette_lcd_line_streamer_core");
		$finish;
	end

	initial begin
		#1000000;
		$display("FAIL palette_lcd_line_streamer_core");
		$finish;
	end

endmodule

>>> filelist.f
design/plls_pkg.sv
design/plls_ram.sv
design/palette_lcd_line_streamer_core.sv
tb/palette_lcd_line_streamer_core_tb.sv
